/* sv/bcs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcs_pkg
// shared constants and types for the byte counting sort core
// ----------------------------------------------------------------------------
package bcs_pkg;

  localparam int unsigned NUM_BINS  = 58;
  localparam int unsigned MAX_ITEMS = 64;

  localparam int unsigned BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

  localparam int unsigned SYM_W = 8;
  localparam int unsigned OUT_W = 7;

  localparam logic [SYM_W-1:0] SYM_LOW  = 8'h41;  // 'A'
  localparam logic [SYM_W-1:0] SYM_HIGH = 8'h7A;  // 'z'

  // request from the sequencer to the histogram store
  typedef struct packed {
    logic             rd_en;
    logic [BIN_W-1:0] rd_addr;
    logic             wr_en;
    logic [BIN_W-1:0] wr_addr;
    logic [CNT_W-1:0] wr_data;
    logic             clr;
  } hist_req_t;

endpackage

/* sv/byte_counting_sort_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_counting_sort_core
// counting sort of byte symbols 'A'..'z' over one batch
// ----------------------------------------------------------------------------
// usage
//   input transaction: symbol and batch_last are taken at a clock edge where
//   start is high and busy is low. a symbol in range that fits the batch
//   capacity is added to its histogram bin; anything else sets the dropped
//   flag of the batch.
//   a counted byte goes through a bin read, then a bin write back through the
//   shared incrementer; a dropped byte that is not last leaves the core idle.
//   on the byte marked batch_last the core scans the bins in ascending order
//   and emits one result transaction per counted byte, marked by result_stb,
//   one per cycle within a bin's run; each visited bin is read and then
//   checked before its run. busy stays high for the whole scan.
//   a batch that counted nothing gives one result with empty_res set.
//   the final result carries run_last; the histogram, count and dropped flag
//   are cleared at that edge and busy drops in the next cycle.
//   results last exactly one cycle; the receiver cannot stall them.
//   reset (rst, synchronous) clears the histogram via its valid bits at once,
//   so the core is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module byte_counting_sort_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [bcs_pkg::SYM_W-1:0] symbol,
  input  logic                      batch_last,
  output logic                      result_stb,
  output logic [bcs_pkg::OUT_W-1:0] sorted_symbol,
  output logic                      run_last,
  output logic                      dropped,
  output logic                      empty_res
);
  import bcs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_EMIT,
    S_EMPTY
  } state_t;

  state_t           state, state_next;
  logic [BIN_W-1:0] bin_q, bin_q_next;       // bin of the byte being counted
  logic             last_q, last_q_next;
  logic [BIN_W-1:0] idx, idx_next;           // scan position
  logic [CNT_W-1:0] rep, rep_next;           // results left in this bin
  logic [CNT_W-1:0] remain, remain_next;     // results left in the batch
  logic [CNT_W-1:0] total, total_next;
  logic             drop_seen, drop_seen_next;

  hist_req_t        req;
  logic [CNT_W-1:0] rd_data;

  // shared incrementer: batch total on accept, bin count on write back
  logic [CNT_W-1:0] inc_a;
  logic [CNT_W-1:0] inc_y;

  // input classification
  logic             accept;
  logic [SYM_W-1:0] sym_off;
  logic             in_range;
  logic             counted;
  logic [SYM_W-1:0] sym_full;

  bcs_hist u_hist (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (rd_data)
  );

  assign accept   = start && (state == S_IDLE);
  assign sym_off  = symbol - SYM_LOW;
  assign in_range = (symbol >= SYM_LOW) && (symbol <= SYM_HIGH)
                    && ({1'b0, sym_off} < (SYM_W + 1)'(NUM_BINS));
  assign counted  = in_range && (total < CNT_W'(MAX_ITEMS));

  assign inc_a = (state == S_UPD) ? rd_data : total;
  assign inc_y = inc_a + CNT_W'(1);

  always_comb begin
    state_next     = state;
    bin_q_next     = bin_q;
    last_q_next    = last_q;
    idx_next       = idx;
    rep_next       = rep;
    remain_next    = remain;
    total_next     = total;
    drop_seen_next = drop_seen;

    req.rd_en   = 1'b0;
    req.rd_addr = idx;
    req.wr_en   = 1'b0;
    req.wr_addr = bin_q;
    req.wr_data = inc_y;
    req.clr     = 1'b0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          last_q_next = batch_last;
          bin_q_next  = sym_off[BIN_W-1:0];
          idx_next    = '0;
          if (counted) begin
            // fetch the bin now, write it back next cycle
            req.rd_en   = 1'b1;
            req.rd_addr = sym_off[BIN_W-1:0];
            total_next  = inc_y;
            state_next  = S_UPD;
          end else begin
            drop_seen_next = 1'b1;
            if (batch_last) begin
              remain_next = total;
              state_next  = (total == '0) ? S_EMPTY : S_SCAN_RD;
            end
          end
        end
      end

      S_UPD: begin
        req.wr_en   = 1'b1;
        remain_next = total;
        state_next  = last_q ? S_SCAN_RD : S_IDLE;
      end

      S_SCAN_RD: begin
        req.rd_en  = 1'b1;
        state_next = S_SCAN_CHK;
      end

      S_SCAN_CHK: begin
        if (rd_data == '0) begin
          idx_next   = idx + BIN_W'(1);
          state_next = S_SCAN_RD;
        end else begin
          rep_next   = rd_data;
          state_next = S_EMIT;
        end
      end

      S_EMIT: begin
        remain_next = remain - CNT_W'(1);
        rep_next    = rep - CNT_W'(1);
        if (remain == CNT_W'(1)) begin
          // final result: start the next batch from scratch
          req.clr        = 1'b1;
          total_next     = '0;
          drop_seen_next = 1'b0;
          state_next     = S_IDLE;
        end else if (rep == CNT_W'(1)) begin
          idx_next   = idx + BIN_W'(1);
          state_next = S_SCAN_RD;
        end
      end

      S_EMPTY: begin
        req.clr        = 1'b1;
        total_next     = '0;
        drop_seen_next = 1'b0;
        state_next     = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= '0;
      drop_seen <= 1'b0;
    end else begin
      state     <= state_next;
      total     <= total_next;
      drop_seen <= drop_seen_next;
    end
    bin_q  <= bin_q_next;
    last_q <= last_q_next;
    idx    <= idx_next;
    rep    <= rep_next;
    remain <= remain_next;
  end

  // result ports follow the sequencer registers
  assign sym_full      = SYM_LOW + SYM_W'(idx);
  assign busy          = (state != S_IDLE);
  assign result_stb    = (state == S_EMIT) || (state == S_EMPTY);
  assign sorted_symbol = (state == S_EMIT) ? sym_full[OUT_W-1:0] : '0;
  assign run_last      = (state == S_EMPTY) || (remain == CNT_W'(1));
  assign dropped       = drop_seen;
  assign empty_res     = (state == S_EMPTY);

  // results only come out while the core holds off new transactions
  a_stb_busy: assert property (@(posedge clk) disable iff (rst)
    result_stb |-> busy)
    else $error("result transaction while not busy");

  // the final result of a batch returns the core to ready
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_stb && run_last) |=> !busy)
    else $error("core still busy after final result");

  // a byte that does not close the batch yields no result
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !batch_last) |=> !result_stb)
    else $error("result after a byte that was not last");

  // an empty batch gives a lone, final, zero result
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (result_stb && empty_res) |-> (run_last && (sorted_symbol == '0)))
    else $error("malformed empty-batch result");

endmodule

/* sv/bcs_hist.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcs_hist
// histogram store: one bin count per symbol, registered read, bulk clear
// ----------------------------------------------------------------------------
module bcs_hist (
  input  logic                    clk,
  input  logic                    rst,
  input  bcs_pkg::hist_req_t      req,
  output logic [bcs_pkg::CNT_W-1:0] rd_data
);
  import bcs_pkg::*;

  logic [CNT_W-1:0]    mem [NUM_BINS];
  logic [NUM_BINS-1:0] valid;
  logic [CNT_W-1:0]    rd_q;
  logic                rd_v;

  // count storage, no reset
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q <= mem[req.rd_addr];
      rd_v <= valid[req.rd_addr];
    end
  end

  // per-bin valid bits stand in for a zero fill
  always_ff @(posedge clk) begin
    if (rst || req.clr) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_v ? rd_q : '0;

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for byte_counting_sort_core: batches of bytes go in
// through start/busy, a scoreboard keeps its own histogram of each batch and
// predicts the ascending run of symbols, and every strobed result is checked
// field by field against the oldest predicted one
// ----------------------------------------------------------------------------
module tb_top;
  import bcs_pkg::*;

  localparam int unsigned CLK_HALF      = 5;
  localparam int unsigned STALL_LIMIT   = 2000;  // a scan of up to 58 bins has long stretches with no transaction
  localparam int unsigned RANDOM_ITEMS  = 300;
  localparam int unsigned IDLE_PCT      = 14;
  localparam int unsigned MAX_REPORTS   = 10;

  // one expected result transaction
  typedef struct {
    logic [OUT_W-1:0] sorted_symbol;
    logic             run_last;
    logic             dropped;
    logic             empty_res;
  } sort_result_t;

  // histogram model of one batch plus the queue of predicted results
  class sort_scoreboard;
    logic [6:0]   bin_cnt [NUM_BINS];
    int unsigned  batch_total;
    logic         batch_drop;
    sort_result_t sorted_q[$];
    int unsigned  mismatches;

    function new();
      mismatches = 0;
      clear_batch();
    endfunction

    function void clear_batch();
      foreach (bin_cnt[i]) bin_cnt[i] = '0;
      batch_total = 0;
      batch_drop  = 1'b0;
    endfunction

    function int unsigned pending();
      return sorted_q.size();
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch @%0t: %s", $realtime, msg);
    endfunction

    // an accepted input transaction: count the byte, emit the run on batch_last
    function void note_byte(logic [SYM_W-1:0] sym, logic last);
      sort_result_t r;
      int unsigned  n;
      if (sym >= SYM_LOW && sym <= SYM_HIGH && (sym - SYM_LOW) < NUM_BINS &&
          batch_total < MAX_ITEMS) begin
        bin_cnt[sym - SYM_LOW] = bin_cnt[sym - SYM_LOW] + 7'd1;
        batch_total++;
      end else begin
        batch_drop = 1'b1;
      end
      if (!last) return;
      if (batch_total == 0) begin
        r.sorted_symbol = '0;
        r.run_last      = 1'b1;
        r.dropped       = batch_drop;
        r.empty_res     = 1'b1;
        sorted_q.push_back(r);
      end else begin
        n = 0;
        for (int b = 0; b < NUM_BINS; b++) begin
          for (int k = 0; k < bin_cnt[b] && n < MAX_ITEMS; k++) begin
            r.sorted_symbol = OUT_W'(SYM_LOW + b);
            r.run_last      = (n + 1 == batch_total);
            r.dropped       = batch_drop;
            r.empty_res     = 1'b0;
            sorted_q.push_back(r);
            n++;
          end
        end
      end
      clear_batch();
    endfunction

    // a strobed result transaction against the oldest prediction
    function void check_result(logic [OUT_W-1:0] sym, logic last, logic drop, logic empty);
      sort_result_t e;
      if (sorted_q.size() == 0) begin
        flag($sformatf("unexpected result sym=%0h last=%0b dropped=%0b empty=%0b",
                       sym, last, drop, empty));
        return;
      end
      e = sorted_q.pop_front();
      if (sym !== e.sorted_symbol || last !== e.run_last || drop !== e.dropped ||
          empty !== e.empty_res)
        flag($sformatf("exp sym=%0h last=%0b dropped=%0b empty=%0b, got %0h %0b %0b %0b",
                       e.sorted_symbol, e.run_last, e.dropped, e.empty_res,
                       sym, last, drop, empty));
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [SYM_W-1:0] symbol = '0;
  logic             batch_last = 1'b0;
  logic             busy;
  logic             result_stb;
  logic [OUT_W-1:0] sorted_symbol;
  logic             run_last;
  logic             dropped;
  logic             empty_res;

  sort_scoreboard sb = new();

  bit          idle_on = 1'b1;   // random gaps between input transactions
  int unsigned counted_items = 0;
  int unsigned stall_cycles = 0;

  byte_counting_sort_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .symbol        (symbol),
    .batch_last    (batch_last),
    .result_stb    (result_stb),
    .sorted_symbol (sorted_symbol),
    .run_last      (run_last),
    .dropped       (dropped),
    .empty_res     (empty_res)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // monitor: values read here are the ones that were stable before the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_byte(symbol, batch_last);
      if (result_stb) sb.check_result(sorted_symbol, run_last, dropped, empty_res);
    end
  end

  // watchdog on cycles where no transaction of either kind happens
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_stb) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // one input transaction, optionally preceded by an idle gap
  task automatic send_byte(input logic [SYM_W-1:0] sym, input logic last);
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start      <= 1'b1;
    symbol     <= sym;
    batch_last <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // hold the sender off until every predicted result has come out
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [SYM_W-1:0] noise_byte();
    if ($urandom_range(1))
      return SYM_W'($urandom_range(0, SYM_LOW - 1));
    return SYM_W'($urandom_range(SYM_HIGH + 1, 255));
  endfunction

  // one batch: len bytes from a window of up to span+1 symbols, noise_pct out of range
  task automatic run_batch(input int unsigned len, input int unsigned noise_pct,
                           input int unsigned span);
    logic [SYM_W-1:0] lo;
    logic [SYM_W-1:0] hi;
    logic [SYM_W-1:0] sym;
    int unsigned      in_batch;
    in_batch = 0;
    lo = SYM_W'($urandom_range(SYM_LOW, SYM_HIGH));
    hi = (lo + span > SYM_HIGH) ? SYM_HIGH : SYM_W'(lo + span);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(99) < noise_pct) begin
        sym = noise_byte();
      end else begin
        sym = SYM_W'($urandom_range(lo, hi));
        // bytes past the batch capacity are dropped by the core, not counted
        if (in_batch < MAX_ITEMS) counted_items++;
        in_batch++;
      end
      send_byte(sym, i == len - 1);
    end
  endtask

  initial begin
    int unsigned batch_idx;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: empty batch from a single out-of-range byte
    send_byte(8'h00, 1'b1);
    // lowest and highest symbol, each alone
    send_byte(SYM_LOW, 1'b1);
    send_byte(SYM_HIGH, 1'b1);
    // bytes just outside the range on both sides, and the top byte
    send_byte(8'h40, 1'b0);
    send_byte(8'h7B, 1'b0);
    send_byte(8'hFF, 1'b1);
    // unordered batch with a repeat and a dropped last byte
    send_byte(SYM_HIGH, 1'b0);
    send_byte(SYM_LOW, 1'b0);
    send_byte(8'h6D, 1'b0);  // 'm'
    send_byte(SYM_LOW, 1'b0);
    send_byte(8'h80, 1'b1);
    // one symbol repeated, clean batch
    send_byte(8'h71, 1'b0);  // 'q'
    send_byte(8'h71, 1'b0);
    send_byte(8'h71, 1'b1);
    // gap between 'Z' and 'a' is inside the range
    send_byte(8'h5B, 1'b0);  // '['
    send_byte(8'h60, 1'b1);  // '`'

    batch_idx = 0;
    while (counted_items < RANDOM_ITEMS) begin
      // a long stretch of back-to-back transactions
      idle_on = !(batch_idx >= 6 && batch_idx < 12);
      if (batch_idx == 3) begin
        // fills the batch exactly, then one more byte beyond capacity
        run_batch(MAX_ITEMS + 1, 0, 57);
      end else begin
        case ($urandom_range(9))
          0:       run_batch($urandom_range(60, 72), 5, 57);  // may overfill
          1:       run_batch($urandom_range(1, 4), 100, 0);   // noise only
          2:       run_batch($urandom_range(2, 20), 0, 2);    // many repeats
          3:       run_batch(1, 0, 57);                       // single byte
          default: run_batch($urandom_range(1, 16), 10, 57);
        endcase
      end
      if (batch_idx == 9) drain_results();
      batch_idx++;
    end

    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    // catch any stray results after the last batch
    repeat (200) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
sv/bcs_pkg.sv
sv/bcs_hist.sv
sv/byte_counting_sort_core.sv
sim/tb_top.sv
